/* hdl/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Grid geometry, command and character codes, cell and payload structs.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 4;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // cursor can run a few cells past the grid before the scroll
  localparam int ADDR_W  = 11;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int TAB_W   = $clog2(TAB_WIDTH + 1);

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  localparam logic [7:0] RESET_ATTR = 8'h0F;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] chr;
  } cell_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [7:0]        char_code;
    logic [ADDR_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_cell;
    logic [7:0]        read_char;
    logic [7:0]        read_attr;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    cell_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_TAB,
    ST_READ,
    ST_SCR_PRIME,
    ST_SCR_COPY,
    ST_SCR_BLANK
  } state_t;

endpackage

/* hdl/tcw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram: simple dual-port synchronous ram
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int DEPTH  = 2000,
  parameter int WIDTH  = 16,
  parameter int AW     = 11
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/tcw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl: console sequencer
// Cursor tracking, command decode and the sweeps for init, clear and scroll.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data,
  output logic      out_valid,
  output out_item_t out_data,
  output mem_req_t  mem_req,
  input  cell_t     mem_rdata
);

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW   = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELL_COUNT - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] CELLS      = ADDR_W'(CELL_COUNT);
  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [TAB_W-1:0]  LAST_TAB   = TAB_W'(TAB_WIDTH - 1);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [TAB_W-1:0]  tab_cnt_r, tab_cnt_nxt;
  logic [7:0]        attr_r, attr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  cell_t             blank;
  logic [COL_W-1:0]  col_inc;

  assign blank     = '{attr: attr_r, chr: CHAR_SPACE};
  assign col_inc   = (col_r == LAST_COL) ? '0 : col_r + COL_W'(1);
  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cursor_r    <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      tab_cnt_r   <= '0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      tab_cnt_r   <= tab_cnt_nxt;
      attr_r      <= attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    tab_cnt_nxt   = tab_cnt_r;
    attr_nxt      = (cfg_valid && cfg_ready) ? cfg_data : attr_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_req       = '0;

    unique case (state_r)
      ST_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = '{attr: RESET_ATTR, chr: CHAR_SPACE};
        cnt_nxt       = cnt_r + ADDR_W'(1);
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          out_data_nxt = '{cursor_cell: cursor_r, read_char: '0, read_attr: '0};
          unique case (in_data.command)
            CMD_PUT: begin
              priority if (in_data.char_code == CHAR_NUL) begin
                out_valid_nxt = 1'b1;
              end else if (in_data.char_code == CHAR_LF) begin
                cursor_nxt = cursor_r - ADDR_W'(col_r) + COLS_A;
                col_nxt    = '0;
                if (cursor_nxt >= CELLS) begin
                  state_nxt = ST_SCR_PRIME;
                end else begin
                  out_valid_nxt            = 1'b1;
                  out_data_nxt.cursor_cell = cursor_nxt;
                end
              end else if (in_data.char_code == CHAR_BS) begin
                if (cursor_r != '0) begin
                  cursor_nxt    = cursor_r - ADDR_W'(1);
                  col_nxt       = (col_r == '0) ? LAST_COL : col_r - COL_W'(1);
                  mem_req.we    = 1'b1;
                  mem_req.waddr = cursor_nxt;
                  mem_req.wdata = blank;
                end
                out_valid_nxt            = 1'b1;
                out_data_nxt.cursor_cell = cursor_nxt;
              end else if (in_data.char_code == CHAR_TAB) begin
                tab_cnt_nxt = '0;
                state_nxt   = ST_TAB;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cursor_r;
                mem_req.wdata = '{attr: attr_r, chr: in_data.char_code};
                cursor_nxt    = cursor_r + ADDR_W'(1);
                col_nxt       = col_inc;
                if (cursor_nxt >= CELLS) begin
                  state_nxt = ST_SCR_PRIME;
                end else begin
                  out_valid_nxt            = 1'b1;
                  out_data_nxt.cursor_cell = cursor_nxt;
                end
              end
            end
            CMD_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            CMD_READ: begin
              if (in_data.cell_index < CELLS) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = in_data.cell_index;
                state_nxt     = ST_READ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = blank;
        cnt_nxt       = cnt_r + ADDR_W'(1);
        cursor_nxt    = '0;
        col_nxt       = '0;
        if (cnt_r == LAST_CELL) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{cursor_cell: '0, read_char: '0, read_attr: '0};
        end
      end

      ST_TAB: begin
        // blanks past the last cell are dropped
        if (cursor_r < CELLS) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cursor_r;
          mem_req.wdata = blank;
        end
        cursor_nxt  = cursor_r + ADDR_W'(1);
        col_nxt     = col_inc;
        tab_cnt_nxt = tab_cnt_r + TAB_W'(1);
        if (tab_cnt_r == LAST_TAB) begin
          if (cursor_nxt >= CELLS) begin
            state_nxt = ST_SCR_PRIME;
          end else begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{cursor_cell: cursor_nxt, read_char: '0, read_attr: '0};
          end
        end
      end

      ST_READ: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{cursor_cell: cursor_r, read_char: mem_rdata.chr,
                          read_attr: mem_rdata.attr};
      end

      ST_SCR_PRIME: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = COLS_A;
        cnt_nxt       = '0;
        cursor_nxt    = LAST_ROW;
        col_nxt       = '0;
        state_nxt     = ST_SCR_COPY;
      end

      ST_SCR_COPY: begin
        // read runs one row ahead of the write, so no overlap on an entry
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = mem_rdata;
        if (cnt_r == LAST_COPY) begin
          cnt_nxt   = LAST_ROW;
          state_nxt = ST_SCR_BLANK;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = cnt_r + COLS_A + ADDR_W'(1);
          cnt_nxt       = cnt_r + ADDR_W'(1);
        end
      end

      ST_SCR_BLANK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = blank;
        cnt_nxt       = cnt_r + ADDR_W'(1);
        if (cnt_r == LAST_CELL) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{cursor_cell: cursor_r, read_char: '0, read_attr: '0};
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: 80x25 text-mode console engine
// Cell store in a synchronous ram plus a sequencer for cursor and scrolling.
// ----------------------------------------------------------------------------
// Usage:
//   in_data (command, char_code, cell_index) is taken at a clock edge where
//   start is high and busy is low. Each item gives one result on out_data,
//   marked by out_valid for exactly one cycle; the receiver cannot stall.
//   cfg_data sets the text attribute; cfg_ready is always high, write it
//   only while busy is low.
//   Per command:
//     put of a plain character, newline, backspace, code zero, unused
//     command, out-of-range read: result in the cycle after the transfer, and
//     the next item may follow in the next cycle
//     read: ram data captured in ST_READ, then registered; tab: TAB_WIDTH blanks
//     written in ST_TAB; clear: one cell written per cycle over all 2000 cells
//     a put that passes the last cell adds a scroll: a ram
//     copy of one cell per cycle over the upper rows, then the last row
//   Reset: after rst_n, busy stays high while all 2000 cells of the ram are
//   swept to spaces with attribute 0x0F; the cursor starts at cell 0.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  output out_item_t  out_data
);

  mem_req_t mem_req;
  cell_t    mem_rdata;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  tcw_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH ($bits(cell_t)),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

/* sim/text_console_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_checker: screen model and result compare for the console
// Watches command, attribute and result transfers, keeps its own copy of the
// cell grid and cursor, and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module text_console_checker
  import tcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_item_t   in_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       out_valid,
  input  out_item_t  out_data,
  output int         errors,
  output int         outstanding,
  output int         checked,
  output int         scrolls
);

  cell_t       screen [CELL_COUNT];
  int unsigned cursor;
  logic [7:0]  text_attr;
  out_item_t   reply_q [$];
  out_item_t   want;

  function automatic void write_cell(int unsigned idx, logic [7:0] chr);
    if (idx < CELL_COUNT) begin
      screen[idx] = '{attr: text_attr, chr: chr};
    end
  endfunction

  function automatic void blank_screen(logic [7:0] attr);
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen[i] = '{attr: attr, chr: CHAR_SPACE};
    end
  endfunction

  function automatic void put_code(logic [7:0] code);
    if (code == CHAR_NUL) begin
      return;
    end
    if (code == CHAR_LF) begin
      cursor = (cursor / COLUMNS + 1) * COLUMNS;
    end else if (code == CHAR_BS) begin
      if (cursor > 0) begin
        cursor = cursor - 1;
        write_cell(cursor, CHAR_SPACE);
      end
    end else if (code == CHAR_TAB) begin
      // blanks past the last cell are dropped by write_cell
      for (int k = 0; k < TAB_WIDTH; k++) begin
        write_cell(cursor, CHAR_SPACE);
        cursor = cursor + 1;
      end
    end else begin
      write_cell(cursor, code);
      cursor = cursor + 1;
    end
    if (cursor >= CELL_COUNT) begin
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
        screen[i] = screen[i + COLUMNS];
      end
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
        screen[i] = '{attr: text_attr, chr: CHAR_SPACE};
      end
      cursor  = CELL_COUNT - COLUMNS;
      scrolls = scrolls + 1;
    end
  endfunction

  function automatic out_item_t console_apply(in_item_t item);
    out_item_t r;
    r = '0;
    case (item.command)
      CMD_PUT: begin
        put_code(item.char_code);
      end
      CMD_CLEAR: begin
        blank_screen(text_attr);
        cursor = 0;
      end
      CMD_READ: begin
        if (item.cell_index < CELL_COUNT) begin
          r.read_char = screen[item.cell_index].chr;
          r.read_attr = screen[item.cell_index].attr;
        end
      end
      default: begin
      end
    endcase
    r.cursor_cell = cursor[ADDR_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      blank_screen(RESET_ATTR);
      cursor    = 0;
      text_attr = RESET_ATTR;
      reply_q.delete();
      errors    = 0;
      checked   = 0;
      scrolls   = 0;
    end else begin
      // results are registered after their transfer, so compare first
      if (out_valid) begin
        if (reply_q.size() == 0) begin
          $error("result transfer with no command waiting: cursor %0d",
                 out_data.cursor_cell);
          errors = errors + 1;
        end else begin
          want    = reply_q.pop_front();
          checked = checked + 1;
          if (out_data.cursor_cell !== want.cursor_cell) begin
            $error("cursor_cell: expected %0d, actual %0d",
                   want.cursor_cell, out_data.cursor_cell);
            errors = errors + 1;
          end
          if (out_data.read_char !== want.read_char) begin
            $error("read_char: expected 0x%02h, actual 0x%02h",
                   want.read_char, out_data.read_char);
            errors = errors + 1;
          end
          if (out_data.read_attr !== want.read_attr) begin
            $error("read_attr: expected 0x%02h, actual 0x%02h",
                   want.read_attr, out_data.read_attr);
            errors = errors + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        text_attr = cfg_data;
      end
      if (start && !busy) begin
        reply_q.push_back(console_apply(in_data));
      end
    end
    outstanding = reply_q.size();
  end

endmodule

/* sim/text_console_writer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb: regression for the text console writer
// Directed corner commands, then three random phases of text lines, tabs at
// row and screen ends, backspaces, reads, clears and raw noise, with the
// attribute changed between bursts and the sender idling at varied rates.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int         QUIET_LIMIT = 10000;
  localparam int         TAIL_CYCLES = 8;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data  = '0;
  in_item_t   in_data   = '0;
  logic       busy;
  logic       cfg_ready;
  logic       out_valid;
  out_item_t  out_data;

  int errors;
  int outstanding;
  int checked;
  int scrolls;
  int idle_pct    = 0;
  int sent        = 0;
  int attr_writes = 0;
  int quiet       = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  text_console_writer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  text_console_checker screen_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked),
    .scrolls     (scrolls)
  );

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("text_console_writer regression: fail");
        $finish;
      end
    end
  end

  function automatic in_item_t mk(logic [1:0] cmd, logic [7:0] code,
                                  logic [ADDR_W-1:0] idx);
    in_item_t item;
    item.command    = cmd;
    item.char_code  = code;
    item.cell_index = idx;
    return item;
  endfunction

  // called and returns at a falling edge; start stays high after an item unless idled or settled
  task automatic send(input in_item_t item);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic put(input logic [7:0] code);
    send(mk(CMD_PUT, code, ADDR_W'($urandom_range(2047))));
  endtask

  task automatic read_cell(input logic [ADDR_W-1:0] idx);
    send(mk(CMD_READ, 8'($urandom_range(255)), idx));
  endtask

  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0 || busy) @(negedge clk);
  endtask

  task automatic write_attr(input logic [7:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    attr_writes++;
  endtask

  function automatic logic [7:0] text_code();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) begin
      return CHAR_TAB;
    end else if (roll < 8) begin
      return CHAR_BS;
    end else if (roll < 11) begin
      return 8'($urandom_range(255));
    end
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [ADDR_W-1:0] read_index();
    if ($urandom_range(9) == 0) begin
      return ADDR_W'($urandom_range(CELL_COUNT, 2047));
    end
    return ADDR_W'($urandom_range(CELL_COUNT - 1));
  endfunction

  task automatic random_phase(input int pct, input int count);
    int       stop;
    int       kind;
    int       pick;
    in_item_t item;
    idle_pct = pct;
    stop     = sent + count;
    while (sent < stop) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        // a line of text, sometimes long enough to wrap
        repeat ($urandom_range(0, COLUMNS + 8)) put(text_code());
        if ($urandom_range(9) < 7) begin
          put(CHAR_LF);
        end
      end else if (kind < 62) begin
        repeat ($urandom_range(1, 4)) read_cell(read_index());
      end else if (kind < 68) begin
        // tab landing near, at or across the end of a row, the last one once full
        put(CHAR_LF);
        repeat (COLUMNS - $urandom_range(0, TAB_WIDTH + 1)) begin
          put(8'($urandom_range(32, 126)));
        end
        put(CHAR_TAB);
        read_cell(ADDR_W'(CELL_COUNT - 1));
      end else if (kind < 74) begin
        repeat ($urandom_range(1, 6)) put(CHAR_BS);
      end else if (kind < 77) begin
        send(mk(CMD_CLEAR, 8'($urandom_range(255)), ADDR_W'($urandom_range(2047))));
      end else if (kind < 80) begin
        pick = $urandom_range(3);
        write_attr(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          item = mk(2'($urandom_range(3)), 8'($urandom_range(255)),
                    ADDR_W'($urandom_range(2047)));
          if (item.command == CMD_CLEAR && $urandom_range(3) != 0) begin
            item.command = CMD_PUT;
          end
          send(item);
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: fresh grid, range edges, cursor corner cases
    read_cell(0);
    read_cell(ADDR_W'(CELL_COUNT - 1));
    read_cell(ADDR_W'(CELL_COUNT));
    read_cell(2047);
    put(CHAR_BS);
    put(CHAR_NUL);
    send(mk(CMD_UNUSED, 8'hFF, 11'h7FF));
    put(8'd65);
    put(8'hFF);
    put(8'h01);
    put(CHAR_TAB);
    put(CHAR_BS);
    put(CHAR_LF);
    read_cell(0);
    read_cell(1);
    read_cell(5);
    read_cell(6);
    write_attr(8'h00);
    put(8'h7E);
    send(mk(CMD_CLEAR, 8'h00, 11'h000));
    read_cell(0);
    read_cell(ADDR_W'(CELL_COUNT - 1));
    write_attr(8'hFF);
    put(8'h80);
    read_cell(0);

    random_phase(8, 610);
    write_attr(8'($urandom_range(255)));
    random_phase(71, 610);
    write_attr(8'h00);
    random_phase(0, 610);

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d commands, %0d results checked, %0d scrolls, %0d attribute writes",
             sent, checked, scrolls, attr_writes);
    $display("sender idled at 8, 71 and 0 percent over the three random phases");
    if (errors == 0 && outstanding == 0) begin
      $display("text_console_writer regression: pass");
    end else begin
      $display("text_console_writer regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer.sv
sim/text_console_checker.sv
sim/text_console_writer_tb.sv
